// ===== hdl/rzoc_pkg.sv =====
// Shared types and constants of the rotor zero-offset calibrator.
package rzoc_pkg;

   // Operation carried by an input item.
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_ABORT = 2'd2
   } op_type;

   // Calibration phase, which is also the reported status.
   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_ALIGN = 3'd1,
      PH_SPIN  = 3'd2,
      PH_DONE  = 3'd3,
      PH_FAIL  = 3'd4
   } phase_type;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_ALIGN_DURATION   = 3'd0,
      CSR_SPIN_DURATION    = 3'd1,
      CSR_ELECTRICAL_SPEED = 3'd2,
      CSR_MINIMUM_MOVEMENT = 3'd3,
      CSR_POLE_PAIR_COUNT  = 3'd4,
      CSR_ALIGN_VOLTAGE    = 3'd5,
      CSR_SPIN_VOLTAGE     = 3'd6
   } csr_index_type;

   localparam int unsigned CsrIndexBits = 3;
   localparam int unsigned CsrDataBits  = 32;
   localparam int unsigned TickBits     = 24;
   localparam int unsigned SpeedBits    = 32;
   localparam int unsigned ElapsedBits  = 16;
   localparam int unsigned PortAngleBits = 16;
   localparam int unsigned VoltageBits  = 16;
   localparam int unsigned MovementBits = 15;
   localparam int unsigned PoleBits     = 7;
   // The angle step is the speed-time product with sixteen fraction bits dropped.
   localparam int unsigned StepShift    = 16;

   // Configuration register contents.
   typedef struct packed {
      logic        [TickBits-1:0]     align_duration;
      logic        [TickBits-1:0]     spin_duration;
      logic signed [SpeedBits-1:0]    electrical_speed;
      logic        [MovementBits-1:0] minimum_movement;
      logic        [PoleBits-1:0]     pole_pair_count;
      logic signed [VoltageBits-1:0]  align_voltage;
      logic signed [VoltageBits-1:0]  spin_voltage;
   } cfg_type;

endpackage

// ===== hdl/rzoc_channels_if.sv =====
// Valid/ready channel interfaces for the calibrator's items and results.
interface rzoc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] elapsed_us;
   logic [15:0] mech_angle;

   modport source (output valid, output op, output elapsed_us, output mech_angle,
                   input ready);
   modport sink (input valid, input op, input elapsed_us, input mech_angle,
                 output ready);
endinterface

interface rzoc_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic               drive_active;
   logic signed [15:0] d_voltage;
   logic signed [15:0] q_voltage;
   logic [15:0]        command_angle;
   logic               direction_reversed;
   logic [15:0]        zero_offset;

   modport source (output valid, output status, output drive_active, output d_voltage,
                   output q_voltage, output command_angle, output direction_reversed,
                   output zero_offset, input ready);
   modport sink (input valid, input status, input drive_active, input d_voltage,
                 input q_voltage, input command_angle, input direction_reversed,
                 input zero_offset, output ready);
endinterface

// ===== hdl/rotor_zero_offset_calibrator_top.sv =====
// Top level of the rotor zero-offset calibrator.
//
//  Channel   Direction  Handshake         Payload
//  req_if    in         valid / ready     op, elapsed_us, mech_angle
//  rsp_if    out        valid / ready     status, drive_active, d/q_voltage,
//                                         command_angle, direction_reversed, zero_offset
//  csr_*     in         csr_wr_en         csr_index, csr_wdata
//
// One item is accepted per cycle unless a stalled result keeps the input register full.
// The input register captures the item with its speed-time angle step; the phase logic
// then updates the state and loads the result register, which offers the result.
// Reset is synchronous; no clearing pass is needed.
// A stalled result holds its register, and the input register fills behind it.
module rotor_zero_offset_calibrator_top
   import rzoc_pkg::*;
#(
   parameter int unsigned ANGLE_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   rzoc_req_if.sink                req_if,
   rzoc_rsp_if.source              rsp_if,
   input  logic                    csr_wr_en,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CsrDataBits-1:0]  csr_wdata
);

   cfg_type               cfg;
   logic                  stg_valid;
   logic                  stg_ready;
   op_type                stg_op;
   logic [ANGLE_BITS-1:0] stg_mech;
   logic [ANGLE_BITS-1:0] stg_step;

   // Configuration registers.
   rzoc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Input register with the angle step product.
   rzoc_input_stage #(.ANGLE_BITS(ANGLE_BITS)) u_input_stage (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .electrical_speed (cfg.electrical_speed),
      .stg_valid        (stg_valid),
      .stg_ready        (stg_ready),
      .stg_op           (stg_op),
      .stg_mech         (stg_mech),
      .stg_step         (stg_step)
   );

   // Phase logic and result register.
   rzoc_core #(.ANGLE_BITS(ANGLE_BITS)) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .stg_valid (stg_valid),
      .stg_ready (stg_ready),
      .stg_op    (stg_op),
      .stg_mech  (stg_mech),
      .stg_step  (stg_step),
      .rsp_if    (rsp_if)
   );

endmodule

// ===== hdl/rzoc_csr.sv =====
// Configuration register bank of the calibrator.
module rzoc_csr
   import rzoc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CsrDataBits-1:0]  csr_wdata,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write and replace the addressed register; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ALIGN_DURATION:   cfg_in.align_duration   = csr_wdata[TickBits-1:0];
            CSR_SPIN_DURATION:    cfg_in.spin_duration    = csr_wdata[TickBits-1:0];
            CSR_ELECTRICAL_SPEED: cfg_in.electrical_speed = signed'(csr_wdata[SpeedBits-1:0]);
            CSR_MINIMUM_MOVEMENT: cfg_in.minimum_movement = csr_wdata[MovementBits-1:0];
            CSR_POLE_PAIR_COUNT:  cfg_in.pole_pair_count  = csr_wdata[PoleBits-1:0];
            CSR_ALIGN_VOLTAGE:    cfg_in.align_voltage    = signed'(csr_wdata[VoltageBits-1:0]);
            CSR_SPIN_VOLTAGE:     cfg_in.spin_voltage     = signed'(csr_wdata[VoltageBits-1:0]);
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Registers with their documented reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.align_duration   <= TickBits'(1000);
         cfg_ff.spin_duration    <= TickBits'(1000);
         cfg_ff.electrical_speed <= '0;
         cfg_ff.minimum_movement <= '0;
         cfg_ff.pole_pair_count  <= PoleBits'(1);
         cfg_ff.align_voltage    <= '0;
         cfg_ff.spin_voltage     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/rzoc_input_stage.sv =====
// Input register of the calibrator: captures an item and its angle step.
module rzoc_input_stage
   import rzoc_pkg::*;
#(
   parameter int unsigned ANGLE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   rzoc_req_if.sink                 req_if,
   input  logic signed [SpeedBits-1:0] electrical_speed,
   output logic                     stg_valid,
   input  logic                     stg_ready,
   output op_type                   stg_op,
   output logic [ANGLE_BITS-1:0]    stg_mech,
   output logic [ANGLE_BITS-1:0]    stg_step
);

   localparam int unsigned ProdBits = SpeedBits + ElapsedBits + 1;

   logic                        valid_ff, valid_in;
   op_type                      op_ff;
   logic [ANGLE_BITS-1:0]       mech_ff;
   logic [ANGLE_BITS-1:0]       step_ff;
   logic signed [ProdBits-1:0]  prod;
   logic                        accept;

   // The stage takes a new item whenever it is empty or its item moves on.
   assign req_if.ready = !valid_ff || stg_ready;
   assign accept       = req_if.valid && req_if.ready;

   // Speed times elapsed time; only the whole angle units are kept, modulo one turn.
   assign prod = electrical_speed * signed'({1'b0, req_if.elapsed_us});

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (stg_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload capture.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_type'(req_if.op);
         mech_ff <= ANGLE_BITS'(req_if.mech_angle);
         step_ff <= prod[StepShift +: ANGLE_BITS];
      end
   end

   assign stg_valid = valid_ff;
   assign stg_op    = op_ff;
   assign stg_mech  = mech_ff;
   assign stg_step  = step_ff;

endmodule

// ===== hdl/rzoc_core.sv =====
// Calibration state machine and result register.
module rzoc_core
   import rzoc_pkg::*;
#(
   parameter int unsigned ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  stg_valid,
   output logic                  stg_ready,
   input  op_type                stg_op,
   input  logic [ANGLE_BITS-1:0] stg_mech,
   input  logic [ANGLE_BITS-1:0] stg_step,
   rzoc_rsp_if.source            rsp_if
);

   localparam logic [ANGLE_BITS-1:0] AngleHalf = {1'b1, {(ANGLE_BITS-1){1'b0}}};

   // Calibration state.
   phase_type             phase_ff, phase_in;
   logic [TickBits-1:0]   tick_ff, tick_in;
   logic [ANGLE_BITS-1:0] cmd_angle_ff, cmd_angle_in;
   logic [ANGLE_BITS-1:0] aligned_ff, aligned_in;
   logic                  reversed_ff, reversed_in;
   logic [ANGLE_BITS-1:0] offset_ff, offset_in;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   phase_type               status_ff, status_in;
   logic                    drive_ff, drive_in;
   logic signed [VoltageBits-1:0] d_ff, d_in, q_ff, q_in;
   logic [PortAngleBits-1:0] angle_out_ff, angle_out_in;
   logic                    dir_out_ff;
   logic [PortAngleBits-1:0] offset_out_ff, offset_out_in;

   logic                           load;
   logic [TickBits-1:0]            tick_next;
   logic [ANGLE_BITS-1:0]          move;
   logic                           move_negative;
   logic [ANGLE_BITS-1:0]          move_mag;
   logic [ANGLE_BITS+PoleBits-1:0] scaled_full;
   logic [ANGLE_BITS-1:0]          scaled;
   logic                           move_enough;

   // The result register loads when it is empty or its result is being taken.
   assign stg_ready = !rsp_valid_ff || rsp_if.ready;
   assign load      = stg_valid && stg_ready;

   // Spin end evaluation: signed movement wrapped to half a turn, and the offset.
   assign tick_next     = tick_ff + TickBits'(1);
   assign move          = stg_mech - aligned_ff;
   assign move_negative = move > AngleHalf;
   assign move_mag      = move_negative ? (ANGLE_BITS'(0) - move) : move;
   assign move_enough   = 32'(move_mag) > 32'(cfg.minimum_movement);
   assign scaled_full   = cfg.pole_pair_count * aligned_ff;
   assign scaled        = scaled_full[ANGLE_BITS-1:0];

   // Next state for one item.
   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      cmd_angle_in = cmd_angle_ff;
      aligned_in   = aligned_ff;
      reversed_in  = reversed_ff;
      offset_in    = offset_ff;
      if (load) begin
         unique case (stg_op)
            OP_START: begin
               phase_in     = PH_ALIGN;
               tick_in      = '0;
               cmd_angle_in = '0;
               aligned_in   = stg_mech;
               reversed_in  = 1'b0;
               offset_in    = '0;
            end
            OP_ABORT: begin
               phase_in     = PH_IDLE;
               tick_in      = '0;
               cmd_angle_in = '0;
            end
            OP_TICK: begin
               if (phase_ff == PH_ALIGN) begin
                  tick_in = tick_next;
                  if (tick_next >= cfg.align_duration) begin
                     aligned_in = stg_mech;
                     tick_in    = '0;
                     phase_in   = PH_SPIN;
                  end
               end else if (phase_ff == PH_SPIN) begin
                  cmd_angle_in = cmd_angle_ff + stg_step;
                  tick_in      = tick_next;
                  if (tick_next >= cfg.spin_duration) begin
                     if (move_enough) begin
                        reversed_in = move_negative;
                        offset_in   = move_negative ? scaled : (ANGLE_BITS'(0) - scaled);
                        phase_in    = PH_DONE;
                     end else begin
                        phase_in = PH_FAIL;
                     end
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Result fields, taken from the state after the item.
   always_comb begin
      status_in     = phase_in;
      drive_in      = (phase_in == PH_ALIGN) || (phase_in == PH_SPIN);
      d_in          = (phase_in == PH_ALIGN) ? cfg.align_voltage : '0;
      q_in          = (phase_in == PH_SPIN) ? cfg.spin_voltage : '0;
      angle_out_in  = '0;
      if (phase_in == PH_SPIN) begin
         angle_out_in = PortAngleBits'(32'(cmd_angle_in));
      end
      offset_out_in = PortAngleBits'(32'(offset_in));
      rsp_valid_in  = load ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         cmd_angle_ff <= '0;
         aligned_ff   <= '0;
         reversed_ff  <= 1'b0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         cmd_angle_ff <= cmd_angle_in;
         aligned_ff   <= aligned_in;
         reversed_ff  <= reversed_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (load) begin
         status_ff     <= status_in;
         drive_ff      <= drive_in;
         d_ff          <= d_in;
         q_ff          <= q_in;
         angle_out_ff  <= angle_out_in;
         dir_out_ff    <= reversed_in;
         offset_out_ff <= offset_out_in;
      end
   end

   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.status             = status_ff;
   assign rsp_if.drive_active       = drive_ff;
   assign rsp_if.d_voltage          = d_ff;
   assign rsp_if.q_voltage          = q_ff;
   assign rsp_if.command_angle      = angle_out_ff;
   assign rsp_if.direction_reversed = dir_out_ff;
   assign rsp_if.zero_offset        = offset_out_ff;

   // The state only moves when an item passes into the result register.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !load |=> $stable(phase_ff) && $stable(tick_ff) && $stable(cmd_angle_ff))
      else $error("calibration state changed without an item");

   // A waiting result is not overwritten.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_if.ready |=> rsp_valid_ff && $stable(status_ff)
         && $stable(offset_out_ff))
      else $error("pending result was lost");

   // Drive is reported exactly in the driving phases.
   a_drive_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> drive_ff == ((status_ff == PH_ALIGN) || (status_ff == PH_SPIN)))
      else $error("drive flag disagrees with status");

   // The tick counter is clear while idle.
   a_tick_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (tick_ff == '0))
      else $error("tick counter running while idle");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the rotor zero-offset calibrator top level.
`timescale 1ns / 1ps

module tb_top;
   import rzoc_pkg::*;

   // Run constants.
   localparam int unsigned ResetCycles          = 8;
   localparam int unsigned SettleCycles         = 4;
   localparam int unsigned WatchdogLimit        = 1000;
   localparam int unsigned RandomItems          = 1200;
   localparam int unsigned HoldOffCycles        = 80;
   localparam int unsigned MaxPrintedMismatches = 40;
   localparam int unsigned CalibrationGuard     = 200;

   // Codes with no member in the package enums, and the half-turn angle.
   localparam logic [1:0]              OpReserved     = 2'd3;
   localparam logic [CsrIndexBits-1:0] CsrUnusedIndex = 3'd7;
   localparam logic [15:0]             HalfTurn       = 16'h8000;

   // One expected result item.
   typedef struct {
      phase_type   status;
      logic        drive_active;
      logic [15:0] d_voltage;
      logic [15:0] q_voltage;
      logic [15:0] command_angle;
      logic        direction_reversed;
      logic [15:0] zero_offset;
   } calib_result_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_wr_en;
   logic [CsrIndexBits-1:0] csr_index;
   logic [CsrDataBits-1:0]  csr_wdata;

   rzoc_req_if req_ch ();
   rzoc_rsp_if rsp_ch ();

   rotor_zero_offset_calibrator_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Predicted block state and register contents.
   cfg_type     cal_cfg;
   phase_type   cal_phase;
   logic [23:0] cal_ticks;
   logic [15:0] cmd_angle;
   logic [15:0] latched_angle;
   logic        reversed;
   logic [15:0] offset;

   calib_result_type awaited_commands [$];
   int unsigned   mismatch_count = 0;
   int unsigned   result_count = 0;
   int unsigned   calib_items = 0;
   int unsigned   quiet_cycles = 0;
   int unsigned   rsp_hold_request = 0;
   bit            send_gaps_on = 1'b1;
   bit            rsp_stall_on = 1'b1;

   // Applies one item to the predicted state and returns the command it should produce.
   function automatic calib_result_type advance_calibration(input logic [1:0] op,
                                                            input logic [15:0] elapsed,
                                                            input logic [15:0] mech);
      calib_result_type result;
      longint        product;
      logic [15:0]   angle_step;
      logic [15:0]   travel;
      logic [15:0]   span;
      logic [15:0]   scaled;
      logic          backwards;
      case (op)
         OP_START: begin
            cal_phase     = PH_ALIGN;
            cal_ticks     = '0;
            cmd_angle     = '0;
            latched_angle = mech;
            reversed      = 1'b0;
            offset        = '0;
         end
         OP_ABORT: begin
            cal_phase = PH_IDLE;
            cal_ticks = '0;
            cmd_angle = '0;
         end
         OP_TICK: begin
            if (cal_phase == PH_ALIGN) begin
               cal_ticks = cal_ticks + 24'd1;
               if (cal_ticks >= cal_cfg.align_duration) begin
                  latched_angle = mech;
                  cal_ticks     = '0;
                  cal_phase     = PH_SPIN;
               end
            end else if (cal_phase == PH_SPIN) begin
               // The fraction below one angle unit is dropped on every tick.
               product    = longint'($signed(cal_cfg.electrical_speed)) * longint'(elapsed);
               angle_step = 16'(product >>> StepShift);
               cmd_angle  = cmd_angle + angle_step;
               cal_ticks  = cal_ticks + 24'd1;
               if (cal_ticks >= cal_cfg.spin_duration) begin
                  // Signed movement wrapped to half a turn; exactly half a turn is forward.
                  travel    = mech - latched_angle;
                  backwards = travel > HalfTurn;
                  span      = backwards ? 16'(16'd0 - travel) : travel;
                  if (span > {1'b0, cal_cfg.minimum_movement}) begin
                     scaled    = 16'(latched_angle * cal_cfg.pole_pair_count);
                     reversed  = backwards;
                     offset    = backwards ? scaled : 16'(16'd0 - scaled);
                     cal_phase = PH_DONE;
                  end else begin
                     cal_phase = PH_FAIL;
                  end
               end
            end
         end
         default: ;
      endcase
      result.status             = cal_phase;
      result.drive_active       = (cal_phase == PH_ALIGN) || (cal_phase == PH_SPIN);
      result.d_voltage          = (cal_phase == PH_ALIGN) ? cal_cfg.align_voltage : '0;
      result.q_voltage          = (cal_phase == PH_SPIN) ? cal_cfg.spin_voltage : '0;
      result.command_angle      = (cal_phase == PH_SPIN) ? cmd_angle : '0;
      result.direction_reversed = reversed;
      result.zero_offset        = offset;
      return result;
   endfunction

   // Gap length for either side: mostly short, now and then long.
   function automatic int unsigned idle_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   function automatic cfg_type random_settings();
      cfg_type s;
      s.align_duration   = 24'(($urandom_range(0, 4) == 0) ? $urandom_range(13, 40)
                                                           : $urandom_range(0, 12));
      s.spin_duration    = 24'(($urandom_range(0, 4) == 0) ? $urandom_range(13, 40)
                                                           : $urandom_range(0, 12));
      s.electrical_speed = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom();
      s.minimum_movement = 15'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 200)
                                                           : $urandom());
      case ($urandom_range(0, 9))
         0:       s.pole_pair_count = '0;
         1:       s.pole_pair_count = 7'($urandom_range(65, 127));
         default: s.pole_pair_count = 7'($urandom_range(1, 64));
      endcase
      s.align_voltage    = 16'($urandom());
      s.spin_voltage     = 16'($urandom());
      return s;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < MaxPrintedMismatches) begin
         $display("%0t: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   // Offers one item, optionally after a gap, and predicts its result once accepted.
   task automatic send_item(input logic [1:0] op, input logic [15:0] elapsed,
                            input logic [15:0] mech);
      int unsigned gap;
      gap = (send_gaps_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.op         <= op;
      req_ch.elapsed_us <= elapsed;
      req_ch.mech_angle <= mech;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      awaited_commands.push_back(advance_calibration(op, elapsed, mech));
   endtask

   // Stops offering items and waits until every expected result has come back.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (awaited_commands.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Writes every register, optionally with junk above each narrower field and a write to
   // the unused index, then records the new contents.
   task automatic load_settings(input cfg_type s, input bit dirty);
      csr_index_type reg_sel;
      logic [31:0]   noise;
      logic [31:0]   word;
      reg_sel = reg_sel.first();
      do begin
         noise = dirty ? $urandom() : 32'd0;
         case (reg_sel)
            CSR_ALIGN_DURATION:   word = {noise[31:24], s.align_duration};
            CSR_SPIN_DURATION:    word = {noise[31:24], s.spin_duration};
            CSR_ELECTRICAL_SPEED: word = s.electrical_speed;
            CSR_MINIMUM_MOVEMENT: word = {noise[31:15], s.minimum_movement};
            CSR_POLE_PAIR_COUNT:  word = {noise[31:7], s.pole_pair_count};
            CSR_ALIGN_VOLTAGE:    word = {noise[31:16], s.align_voltage};
            default:              word = {noise[31:16], s.spin_voltage};
         endcase
         csr_wr_en <= 1'b1;
         csr_index <= reg_sel;
         csr_wdata <= word;
         @(posedge clock);
         reg_sel = reg_sel.next();
      end while (reg_sel != reg_sel.first());
      if (dirty) begin
         csr_wr_en <= 1'b1;
         csr_index <= CsrUnusedIndex;
         csr_wdata <= $urandom();
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      cal_cfg = s;
   endtask

   // One start followed by ticks until the calibration settles, with the odd abort,
   // restart or reserved code thrown in. The last spin tick lands near the threshold.
   task automatic run_calibration();
      logic [1:0]  op;
      logic [15:0] mech;
      logic [15:0] elapsed;
      logic [15:0] delta;
      int unsigned roll;
      int unsigned guard;
      send_item(OP_START, 16'($urandom()), 16'($urandom()));
      calib_items++;
      guard = 0;
      while ((cal_phase == PH_ALIGN || cal_phase == PH_SPIN) && guard < CalibrationGuard) begin
         roll    = $urandom_range(0, 99);
         mech    = 16'($urandom());
         elapsed = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 100) : $urandom());
         if (roll < 2) op = OP_ABORT;
         else if (roll < 4) op = OP_START;
         else if (roll < 6) op = OpReserved;
         else op = OP_TICK;
         if (op == OP_TICK && cal_phase == PH_SPIN &&
             24'(cal_ticks + 24'd1) >= cal_cfg.spin_duration) begin
            case ($urandom_range(0, 5))
               0:       delta = {1'b0, cal_cfg.minimum_movement} + 16'd1;
               1:       delta = {1'b0, cal_cfg.minimum_movement};
               2:       delta = 16'(16'd0 - ({1'b0, cal_cfg.minimum_movement} + 16'd1));
               3:       delta = 16'(16'd0 - {1'b0, cal_cfg.minimum_movement});
               4:       delta = HalfTurn;
               default: delta = 16'($urandom());
            endcase
            mech = latched_angle + delta;
         end
         send_item(op, elapsed, mech);
         guard++;
         calib_items++;
      end
   endtask

   // Default register contents, codes the block ignores and an abort during align.
   task automatic test_reset_state();
      send_item(OP_TICK, 16'hFFFF, 16'hFFFF);
      send_item(OpReserved, 16'h0000, 16'h0000);
      send_item(OP_START, 16'h0000, 16'hABCD);
      send_item(OP_TICK, 16'h8000, 16'h5555);
      send_item(OP_TICK, 16'h0001, 16'hAAAA);
      send_item(OP_ABORT, 16'hFFFF, 16'h0000);
   endtask

   // Field extremes, a zero align duration and a movement of exactly half a turn.
   task automatic test_extremes();
      drain_results();
      load_settings('{align_duration: 24'd0, spin_duration: 24'd2,
                      electrical_speed: 32'h7FFF_FFFF, minimum_movement: 15'h7FFF,
                      pole_pair_count: 7'd127, align_voltage: 16'h8000,
                      spin_voltage: 16'h7FFF}, 1'b1);
      send_item(OP_START, 16'h0000, 16'h1234);
      send_item(OP_TICK, 16'h0000, 16'h4000);
      send_item(OP_TICK, 16'hFFFF, 16'h0000);
      send_item(OP_TICK, 16'hFFFF, 16'hC000);
      send_item(OP_TICK, 16'hFFFF, 16'hFFFF);
      send_item(OpReserved, 16'hFFFF, 16'hFFFF);
      send_item(OP_START, 16'h0000, 16'hFFFF);
      send_item(OP_TICK, 16'h1234, 16'h0000);
      send_item(OP_TICK, 16'hFFFF, 16'h0000);
      send_item(OP_ABORT, 16'h0000, 16'h0000);
      // Longest durations: only the opening ticks can be seen.
      drain_results();
      load_settings('{align_duration: 24'hFF_FFFF, spin_duration: 24'hFF_FFFF,
                      electrical_speed: 32'h8000_0000, minimum_movement: 15'd0,
                      pole_pair_count: 7'd1, align_voltage: 16'h7FFF,
                      spin_voltage: 16'h8000}, 1'b0);
      send_item(OP_START, 16'h0000, 16'h0000);
      send_item(OP_TICK, 16'hFFFF, 16'hFFFF);
      send_item(OpReserved, 16'h0000, 16'h0000);
      send_item(OP_START, 16'h0000, 16'h7777);
      send_item(OP_ABORT, 16'h0000, 16'h0000);
   endtask

   // Too little movement, reverse movement, a pole pair count of zero and a restart.
   task automatic test_outcomes();
      drain_results();
      load_settings('{align_duration: 24'd1, spin_duration: 24'd1,
                      electrical_speed: 32'h8000_0000, minimum_movement: 15'd0,
                      pole_pair_count: 7'd0, align_voltage: 16'h7FFF,
                      spin_voltage: 16'h8000}, 1'b0);
      send_item(OP_START, 16'h0000, 16'h0100);
      send_item(OP_TICK, 16'h0000, 16'h0100);
      send_item(OP_TICK, 16'hFFFF, 16'h0100);
      send_item(OP_TICK, 16'h0010, 16'h0200);
      send_item(OP_ABORT, 16'h0000, 16'h0000);
      send_item(OP_START, 16'h0000, 16'h8000);
      send_item(OP_TICK, 16'h0000, 16'h7000);
      send_item(OP_TICK, 16'hFFFF, 16'h6FFF);
      send_item(OP_START, 16'h0000, 16'h0001);
   endtask

   // The receiver holds off while items keep coming, then the sender waits for the
   // block to empty.
   task automatic test_backpressure();
      drain_results();
      load_settings('{align_duration: 24'd2, spin_duration: 24'd6,
                      electrical_speed: $urandom(), minimum_movement: 15'd10,
                      pole_pair_count: 7'd4, align_voltage: 16'($urandom()),
                      spin_voltage: 16'($urandom())}, 1'b0);
      send_gaps_on     = 1'b0;
      rsp_hold_request = HoldOffCycles;
      repeat (3) begin
         send_item(OP_START, 16'($urandom()), 16'($urandom()));
         repeat (7) send_item(OP_TICK, 16'($urandom()), 16'($urandom()));
      end
      drain_results();
      send_gaps_on = 1'b1;
   endtask

   // Random settings, each followed by a few calibrations with noise between them.
   task automatic test_random_calibrations();
      while (calib_items < RandomItems) begin
         drain_results();
         load_settings(random_settings(), 1'($urandom_range(0, 1)));
         send_gaps_on = $urandom_range(0, 3) != 0;
         rsp_stall_on = $urandom_range(0, 3) != 0;
         repeat ($urandom_range(1, 4)) begin
            repeat ($urandom_range(0, 3))
               send_item(2'($urandom()), 16'($urandom()), 16'($urandom()));
            run_calibration();
         end
      end
   endtask

   // Result side: ready follows random stalls, or a hold-off when one is asked for.
   initial begin : drive_rsp_ready
      int unsigned stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request != 0) begin
            stall            = rsp_hold_request;
            rsp_hold_request = 0;
         end else if (stall == 0 && rsp_stall_on && $urandom_range(0, 3) == 0) begin
            stall = idle_length();
         end
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Each accepted result is compared with the oldest expectation.
   always @(posedge clock) begin : check_results
      calib_result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (awaited_commands.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", result_count));
         end else begin
            want = awaited_commands.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch($sformatf("result %0d status: expected %0d, got %0d",
                                         result_count, want.status, rsp_ch.status));
            if (rsp_ch.drive_active !== want.drive_active)
               report_mismatch($sformatf("result %0d drive_active: expected %b, got %b",
                                         result_count, want.drive_active, rsp_ch.drive_active));
            if (rsp_ch.d_voltage !== want.d_voltage)
               report_mismatch($sformatf("result %0d d_voltage: expected %h, got %h",
                                         result_count, want.d_voltage, rsp_ch.d_voltage));
            if (rsp_ch.q_voltage !== want.q_voltage)
               report_mismatch($sformatf("result %0d q_voltage: expected %h, got %h",
                                         result_count, want.q_voltage, rsp_ch.q_voltage));
            if (rsp_ch.command_angle !== want.command_angle)
               report_mismatch($sformatf("result %0d command_angle: expected %h, got %h",
                                         result_count, want.command_angle,
                                         rsp_ch.command_angle));
            if (rsp_ch.direction_reversed !== want.direction_reversed)
               report_mismatch($sformatf("result %0d direction_reversed: expected %b, got %b",
                                         result_count, want.direction_reversed,
                                         rsp_ch.direction_reversed));
            if (rsp_ch.zero_offset !== want.zero_offset)
               report_mismatch($sformatf("result %0d zero_offset: expected %h, got %h",
                                         result_count, want.zero_offset, rsp_ch.zero_offset));
         end
         result_count++;
      end
   end

   // The run ends if neither channel moves an item for too long.
   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_index         <= '0;
      csr_wdata         <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.op         <= OP_TICK;
      req_ch.elapsed_us <= '0;
      req_ch.mech_angle <= '0;
      rsp_ch.ready      <= 1'b0;
      cal_cfg = '{align_duration: 24'd1000, spin_duration: 24'd1000, electrical_speed: '0,
                  minimum_movement: '0, pole_pair_count: 7'd1, align_voltage: '0,
                  spin_voltage: '0};
      cal_phase     = PH_IDLE;
      cal_ticks     = '0;
      cmd_angle     = '0;
      latched_angle = '0;
      reversed      = 1'b0;
      offset        = '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_extremes();
      test_outcomes();
      test_backpressure();
      test_random_calibrations();
      drain_results();

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/rzoc_pkg.sv
hdl/rzoc_channels_if.sv
hdl/rzoc_csr.sv
hdl/rzoc_input_stage.sv
hdl/rzoc_core.sv
hdl/rotor_zero_offset_calibrator_top.sv
tb/sv/tb_top.sv
